@@ design/siph_pkg.sv @@
// ----------------------------------------------------------------------------
// siph_pkg: shared types and constants for the SipHash-2-4 engine
// Lane bundle, sequencer states, register indexes and initialization values.
// ----------------------------------------------------------------------------
package siph_pkg;

	localparam int unsigned LANE_W = 64;

	localparam logic [LANE_W-1:0] INIT_C0 = 64'h736f_6d65_7073_6575;
	localparam logic [LANE_W-1:0] INIT_C1 = 64'h646f_7261_6e64_6f6d;
	localparam logic [LANE_W-1:0] INIT_C2 = 64'h6c79_6765_6e65_7261;
	localparam logic [LANE_W-1:0] INIT_C3 = 64'h7465_6462_7974_6573;

	localparam logic [LANE_W-1:0] FINAL_XOR = 64'h0000_0000_0000_00ff;

	localparam int unsigned ROT_A = 13;
	localparam int unsigned ROT_B = 16;
	localparam int unsigned ROT_C = 17;
	localparam int unsigned ROT_D = 21;
	localparam int unsigned ROT_HALF = 32;

	localparam int unsigned BYTES_PER_WORD = 8;
	localparam int unsigned LEN_SHIFT = 56;

	typedef struct packed {
		logic [LANE_W-1:0] v0;
		logic [LANE_W-1:0] v1;
		logic [LANE_W-1:0] v2;
		logic [LANE_W-1:0] v3;
	} lanes_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FULL,
		ST_TAIL,
		ST_FINAL
	} state_t;

	// Register index decoded from paddr[3]
	typedef enum logic {
		REG_KEY_LOW  = 1'b0,
		REG_KEY_HIGH = 1'b1
	} reg_idx_t;

endpackage

@@ design/siph_round.sv @@
// ----------------------------------------------------------------------------
// siph_round: one SipRound
// Combinational add-rotate-xor round over the four lanes.
// ----------------------------------------------------------------------------
module siph_round
	import siph_pkg::*;
(
	input  lanes_t lanes_in,
	output lanes_t lanes_out
);

	function automatic logic [LANE_W-1:0] rotl(input logic [LANE_W-1:0] x,
						   input int unsigned s);
		rotl = (x << s) | (x >> (LANE_W - s));
	endfunction

	logic [LANE_W-1:0] a0, a1, a2, a3;
	logic [LANE_W-1:0] b0, b1, b2, b3;

	always_comb begin
		a0 = lanes_in.v0 + lanes_in.v1;
		a1 = rotl(lanes_in.v1, ROT_A) ^ a0;
		a0 = rotl(a0, ROT_HALF);
		a2 = lanes_in.v2 + lanes_in.v3;
		a3 = rotl(lanes_in.v3, ROT_B) ^ a2;
		b0 = a0 + a3;
		b3 = rotl(a3, ROT_D) ^ b0;
		b2 = a2 + a1;
		b1 = rotl(a1, ROT_C) ^ b2;
		b2 = rotl(b2, ROT_HALF);
		lanes_out = '{v0: b0, v1: b1, v2: b2, v3: b3};
	end

endmodule

@@ design/siphash_keyed_hash.sv @@
// ----------------------------------------------------------------------------
// siphash_keyed_hash: SipHash-2-4, 64-bit result, 128-bit key
// Keyed hash over a stream of little-endian 64-bit message words.
// ----------------------------------------------------------------------------
// Usage:
//   Write the key through the APB port: key_low at byte address 0, key_high
//   at byte address 8 (64-bit data). The key is sampled when a message starts.
//   Message words enter on msg_valid/msg_stall; a transfer happens when
//   msg_valid is high and msg_stall is low. last_word marks the final word;
//   valid_bytes (0..8, larger values count as 8) applies to that word only.
//   The hash leaves on hash_valid/hash_stall with hash_value.
// Timing:
//   One SipRound per cycle on a single shared round unit; the last round waits
//   while hash_stall holds a result. A non-last word holds msg_stall through its
//   2 compression rounds, so no word transfers before they finish. A last word
//   runs 2 + 4 = 6 rounds, or 8 when all eight bytes are valid; hash_valid rises
//   as the last round ends, with hash_value registered, and the next word can
//   transfer as hash_valid rises. msg_stall stays high while the rounds run.
// Reset and stall:
//   arst_n clears the key, the lanes and the sequencer; the next word starts
//   a new message. While hash_stall holds a result, the next message runs
//   until its last round and then waits there until the output frees.
// ----------------------------------------------------------------------------
module siphash_keyed_hash
	import siph_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration port
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [63:0]       pwdata,
	output logic [63:0]       prdata,
	output logic              pready,
	// message channel
	input  logic              msg_valid,
	output logic              msg_stall,
	input  logic [63:0]       message_word,
	input  logic [3:0]        valid_bytes,
	input  logic              last_word,
	// hash channel
	output logic              hash_valid,
	input  logic              hash_stall,
	output logic [63:0]       hash_value
);

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [LANE_W-1:0] key_low_q, key_high_q;
	reg_idx_t          reg_idx;
	logic              cfg_write;

	assign pready    = 1'b1;
	assign reg_idx   = reg_idx_t'(paddr[3]);
	assign cfg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (cfg_write) begin
			unique case (reg_idx)
				REG_KEY_LOW:  key_low_q  <= pwdata;
				REG_KEY_HIGH: key_high_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_KEY_LOW:  prdata = key_low_q;
			REG_KEY_HIGH: prdata = key_high_q;
			default:      prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Datapath state
	// ------------------------------------------------------------------
	state_t            state_q, state_d;
	lanes_t            lanes_q, lanes_d;
	logic [LANE_W-1:0] block_q, block_d;    // block being compressed
	logic [7:0]        len_q, len_d;        // message length mod 256
	logic [1:0]        cnt_q, cnt_d;        // round counter
	logic              last_q, last_d;      // current word ends the message
	logic              start_q, start_d;    // next word opens a message
	logic              hvalid_q, hvalid_d;
	logic [LANE_W-1:0] hash_q, hash_d;

	lanes_t            round_out;
	logic              msg_xfer;

	siph_round u_round (
		.lanes_in  (lanes_q),
		.lanes_out (round_out)
	);

	assign msg_stall  = (state_q != ST_IDLE);
	assign msg_xfer   = msg_valid && !msg_stall;
	assign hash_valid = hvalid_q;
	assign hash_value = hash_q;

	// Accept-time preparation: starting lanes, tail word and new length
	lanes_t            base_lanes;
	logic [7:0]        base_len;
	logic [3:0]        nvalid;
	logic              full_last;
	logic [LANE_W-1:0] tail_word;
	logic [7:0]        len_full;
	logic [7:0]        len_tail;

	always_comb begin
		if (start_q) begin
			base_lanes = '{v0: INIT_C0 ^ key_low_q, v1: INIT_C1 ^ key_high_q,
				       v2: INIT_C2 ^ key_low_q, v3: INIT_C3 ^ key_high_q};
			base_len   = '0;
		end else begin
			base_lanes = lanes_q;
			base_len   = len_q;
		end

		nvalid    = (valid_bytes > 4'(BYTES_PER_WORD)) ? 4'(BYTES_PER_WORD) : valid_bytes;
		full_last = (nvalid == 4'(BYTES_PER_WORD));

		// keep only bytes below the valid count
		for (int i = 0; i < BYTES_PER_WORD; i++) begin
			tail_word[i*8 +: 8] = (4'(i) < nvalid) ? message_word[i*8 +: 8] : 8'h00;
		end

		len_full = base_len + 8'(BYTES_PER_WORD);
		len_tail = base_len + {4'h0, nvalid};
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			lanes_q  <= '0;
			len_q    <= '0;
			cnt_q    <= '0;
			last_q   <= 1'b0;
			start_q  <= 1'b1;
			hvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			lanes_q  <= lanes_d;
			len_q    <= len_d;
			cnt_q    <= cnt_d;
			last_q   <= last_d;
			start_q  <= start_d;
			hvalid_q <= hvalid_d;
		end
	end

	always_ff @(posedge clk) begin
		block_q <= block_d;
		hash_q  <= hash_d;
	end

	always_comb begin
		state_d  = state_q;
		lanes_d  = lanes_q;
		block_d  = block_q;
		len_d    = len_q;
		cnt_d    = cnt_q;
		last_d   = last_q;
		start_d  = start_q;
		hash_d   = hash_q;
		// drop the result once the receiver takes it
		hvalid_d = hvalid_q && hash_stall;

		unique case (state_q)
			ST_IDLE: begin
				if (msg_xfer) begin
					start_d = 1'b0;
					last_d  = last_word;
					cnt_d   = '0;
					lanes_d = base_lanes;
					if (!last_word || full_last) begin
						// compress the whole word first
						block_d    = message_word;
						len_d      = len_full;
						lanes_d.v3 = base_lanes.v3 ^ message_word;
						state_d    = ST_FULL;
					end else begin
						block_d    = {len_tail, 56'h0} | tail_word;
						len_d      = len_tail;
						lanes_d.v3 = base_lanes.v3 ^ ({len_tail, 56'h0} | tail_word);
						state_d    = ST_TAIL;
					end
				end
			end

			ST_FULL: begin
				lanes_d = round_out;
				cnt_d   = cnt_q + 2'd1;
				if (cnt_q == 2'd1) begin
					cnt_d      = '0;
					lanes_d.v0 = round_out.v0 ^ block_q;
					if (last_q) begin
						// follow with the length-only block
						block_d    = {len_q, 56'h0};
						lanes_d.v3 = round_out.v3 ^ {len_q, 56'h0};
						state_d    = ST_TAIL;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end

			ST_TAIL: begin
				lanes_d = round_out;
				cnt_d   = cnt_q + 2'd1;
				if (cnt_q == 2'd1) begin
					cnt_d      = '0;
					lanes_d.v0 = round_out.v0 ^ block_q;
					lanes_d.v2 = round_out.v2 ^ FINAL_XOR;
					state_d    = ST_FINAL;
				end
			end

			ST_FINAL: begin
				if (cnt_q != 2'd3) begin
					lanes_d = round_out;
					cnt_d   = cnt_q + 2'd1;
				end else if (!(hvalid_q && hash_stall)) begin
					// hold on the last round while a hash still waits
					lanes_d  = round_out;
					cnt_d    = '0;
					hash_d   = round_out.v0 ^ round_out.v1 ^ round_out.v2 ^ round_out.v3;
					hvalid_d = 1'b1;
					start_d  = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_hash_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(hash_valid) |-> $past(state_q == ST_FINAL))
		else $error("hash_valid rose outside finalization");

	a_accept_starts_work: assert property (@(posedge clk) disable iff (!arst_n)
		msg_xfer |=> (state_q == ST_FULL || state_q == ST_TAIL))
		else $error("accepted word did not start rounds");

	a_two_round_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FULL || state_q == ST_TAIL) |-> cnt_q <= 2'd1)
		else $error("round counter overran a compression");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		msg_xfer |=> !start_q)
		else $error("message start flag not cleared on transfer");

endmodule
